### sv/lgf_pkg.sv
package lgf_pkg;

  // lightmap geometry
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int SUBSAMPLES  = 8;
  localparam int VALUE_BITS  = 48;
  localparam int XW          = 7;
  localparam int YW          = 7;
  localparam int DIM_W       = 8;
  localparam int UV_W        = 17;
  localparam int TEX_AW      = XW + YW;
  localparam int TEX_DEPTH   = MAX_WIDTH * MAX_HEIGHT;

  // fixed point raster grid, in units of 1/(2*S*S) texel
  localparam int SCALE       = 2 * SUBSAMPLES * SUBSAMPLES;
  localparam int SUB_OFS     = 2 * SUBSAMPLES;
  localparam int SUB_STEP    = 2 * (SUBSAMPLES - 2);
  localparam int SUB_W       = $clog2(SUBSAMPLES) > 0 ? $clog2(SUBSAMPLES) : 1;
  localparam int VW          = 20;
  localparam int EW          = 2 * VW + 2;

  // ring search
  localparam int RING_W      = 8;
  localparam int CW          = 10;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [UV_W-1:0] UV_ONE = UV_W'(65536);

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_WRITE = 2'd1,
    FN_TRI   = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DIR_ZERO = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  // request as it travels through the queue
  typedef struct packed {
    func_t                      func;
    logic [XW-1:0]              x;
    logic [YW-1:0]              y;
    logic [VALUE_BITS-1:0]      value;
    logic [5:0][UV_W-1:0]       uv;
  } entry_t;

  typedef struct packed {
    logic init_clear;
  } back_status_t;

  // neighbor offsets of one ring
  function automatic dir_t ring_dx(input logic [2:0] k);
    dir_t d;
    case (k)
      3'd0: d = DIR_NEG;
      3'd1: d = DIR_POS;
      3'd4: d = DIR_NEG;
      3'd5: d = DIR_POS;
      3'd6: d = DIR_NEG;
      3'd7: d = DIR_POS;
      default: d = DIR_ZERO;
    endcase
    return d;
  endfunction

  function automatic dir_t ring_dy(input logic [2:0] k);
    dir_t d;
    case (k)
      3'd2: d = DIR_NEG;
      3'd3: d = DIR_POS;
      3'd4: d = DIR_NEG;
      3'd5: d = DIR_NEG;
      3'd6: d = DIR_POS;
      3'd7: d = DIR_POS;
      default: d = DIR_ZERO;
    endcase
    return d;
  endfunction

  function automatic logic signed [CW-1:0] ring_step(input logic [6:0] c,
                                                     input logic [RING_W-1:0] s,
                                                     input dir_t d);
    logic signed [CW-1:0] base;
    logic signed [CW-1:0] ofs;
    base = $signed(CW'(c));
    ofs  = $signed(CW'(s));
    case (d)
      DIR_POS: return base + ofs;
      DIR_NEG: return base - ofs;
      default: return base;
    endcase
  endfunction

endpackage

### sv/lgf_ram.sv
module lgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/lgf_front.sv
module lgf_front import lgf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic [XW-1:0]         texel_x,
  input  logic [YW-1:0]         texel_y,
  input  logic [VALUE_BITS-1:0] texel_value,
  input  logic [UV_W-1:0]       u_first,
  input  logic [UV_W-1:0]       v_first,
  input  logic [UV_W-1:0]       u_second,
  input  logic [UV_W-1:0]       v_second,
  input  logic [UV_W-1:0]       u_third,
  input  logic [UV_W-1:0]       v_third,
  input  logic [DIM_W-1:0]      w_eff,
  input  logic [DIM_W-1:0]      h_eff,
  input  back_status_t          back_status,
  input  logic                  pop,
  output entry_t                head,
  output logic                  head_valid
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  entry_t           push;
  logic [DIM_W-1:0] wm1;
  logic [DIM_W-1:0] hm1;

  assign busy   = (count == CNT_W'(QUEUE_DEPTH)) || back_status.init_clear;
  assign accept = start && !busy;

  // classify: clamp texel into active area, saturate uvs
  always_comb begin
    wm1 = w_eff - DIM_W'(1);
    hm1 = h_eff - DIM_W'(1);
    push.func  = func_t'(func);
    push.x     = ({1'b0, texel_x} > wm1) ? wm1[XW-1:0] : texel_x;
    push.y     = ({1'b0, texel_y} > hm1) ? hm1[YW-1:0] : texel_y;
    push.value = texel_value;
    push.uv[0] = (u_first  > UV_ONE) ? UV_ONE : u_first;
    push.uv[1] = (v_first  > UV_ONE) ? UV_ONE : v_first;
    push.uv[2] = (u_second > UV_ONE) ? UV_ONE : u_second;
    push.uv[3] = (v_second > UV_ONE) ? UV_ONE : v_second;
    push.uv[4] = (u_third  > UV_ONE) ? UV_ONE : u_third;
    push.uv[5] = (v_third  > UV_ONE) ? UV_ONE : v_third;
  end

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);

  always_comb begin
    count_next = count + CNT_W'(accept) - CNT_W'(pop);
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_ptr] <= push;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count_next;
    end
  end

endmodule

### sv/lgf_back.sv
module lgf_back import lgf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DIM_W-1:0]      w_eff,
  input  logic [DIM_W-1:0]      h_eff,
  input  entry_t                head,
  input  logic                  head_valid,
  output logic                  pop,
  output back_status_t          back_status,
  output logic                  done,
  output logic [VALUE_BITS-1:0] filled_value,
  output logic                  source_found,
  output logic [XW-1:0]         source_x,
  output logic [YW-1:0]         source_y
);

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_CONV    = 14'b00000000000100,
    S_BBOX    = 14'b00000000001000,
    S_SETUP   = 14'b00000000010000,
    S_START   = 14'b00000000100000,
    S_TEST    = 14'b00000001000000,
    S_ROW_RD  = 14'b00000010000000,
    S_ROW_WR  = 14'b00000100000000,
    S_RD_COV  = 14'b00001000000000,
    S_RD_CHK  = 14'b00010000000000,
    S_RD_NEXT = 14'b00100000000000,
    S_RD_VAL  = 14'b01000000000000,
    S_RD_OUT  = 14'b10000000000000
  } state_t;

  state_t state;
  logic   init_clear;

  // request registers
  logic [XW-1:0]        cur_x;
  logic [YW-1:0]        cur_y;
  logic [5:0][UV_W-1:0] uv;
  logic [5:0][XW-1:0]   t;
  logic [2:0]           cidx;
  logic [YW-1:0]        row;

  // raster registers
  logic [XW-1:0]        bx0, bx1;
  logic [YW-1:0]        by0, by1;
  logic [2:0]           step;
  logic signed [EW-1:0] acc [4];
  logic signed [EW-1:0] e_trow [3];
  logic signed [EW-1:0] e_tex [3];
  logic signed [EW-1:0] e_srow [3];
  logic signed [EW-1:0] e_cur [3];
  logic                 area_pos;
  logic [XW-1:0]        ix;
  logic [YW-1:0]        iy;
  logic [SUB_W-1:0]     sx, sy;
  logic [MAX_WIDTH-1:0] hits;

  // search registers
  logic [RING_W-1:0]    s;
  logic [2:0]           k;
  logic [XW-1:0]        cx;
  logic [YW-1:0]        cy;
  logic                 self_chk;
  logic                 found;
  logic [XW-1:0]        src_x;
  logic [YW-1:0]        src_y;

  // memories
  logic                   cov_we;
  logic [YW-1:0]          cov_waddr;
  logic [MAX_WIDTH-1:0]   cov_wdata;
  logic [YW-1:0]          cov_raddr;
  logic [MAX_WIDTH-1:0]   cov_rdata;
  logic                   tex_we;
  logic [VALUE_BITS-1:0]  tex_rdata;

  lgf_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_cov (
    .clk   (clk),
    .we    (cov_we),
    .waddr (cov_waddr),
    .wdata (cov_wdata),
    .raddr (cov_raddr),
    .rdata (cov_rdata)
  );

  lgf_ram #(.WIDTH(VALUE_BITS), .DEPTH(TEX_DEPTH)) u_tex (
    .clk   (clk),
    .we    (tex_we),
    .waddr ({head.y, head.x}),
    .wdata (head.value),
    .raddr ({src_y, src_x}),
    .rdata (tex_rdata)
  );

  // uv to texel conversion, one coordinate a cycle
  logic [DIM_W-1:0]      conv_fac;
  logic [UV_W+DIM_W-1:0] conv_prod;
  always_comb begin
    conv_fac  = cidx[0] ? (h_eff - DIM_W'(1)) : (w_eff - DIM_W'(1));
    conv_prod = (UV_W+DIM_W)'(uv[cidx]) * (UV_W+DIM_W)'(conv_fac);
  end

  // vertices and edge deltas on the raster grid
  logic signed [VW-1:0] vx [3];
  logic signed [VW-1:0] vy [3];
  logic signed [VW-1:0] dx [3];
  logic signed [VW-1:0] dy [3];
  logic signed [EW-1:0] sub_x [3];
  logic signed [EW-1:0] sub_y [3];
  logic signed [EW-1:0] tex_x [3];
  logic signed [EW-1:0] tex_y [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      vx[j] = $signed(VW'(t[2*j]) * VW'(SCALE) + VW'(SCALE / 2));
      vy[j] = $signed(VW'(t[2*j+1]) * VW'(SCALE) + VW'(SCALE / 2));
    end
    for (int j = 0; j < 3; j++) begin
      dx[j]    = vx[(j + 1) % 3] - vx[j];
      dy[j]    = vy[(j + 1) % 3] - vy[j];
      sub_x[j] = EW'(-(EW'(dy[j]) * SUB_STEP));
      sub_y[j] = EW'(EW'(dx[j]) * SUB_STEP);
      tex_x[j] = EW'(-(EW'(dy[j]) * SCALE));
      tex_y[j] = EW'(EW'(dx[j]) * SCALE);
    end
  end

  // edge setup: one multiply a cycle into the accumulators
  logic [1:0]             sr;
  logic [1:0]             ej;
  logic signed [VW-1:0]   px0, py0, qx, qy, opa, opb;
  logic signed [2*VW-1:0] prod;
  always_comb begin
    sr  = step[2:1];
    ej  = (sr == 2'd0) ? 2'd0 : sr - 2'd1;
    px0 = $signed(VW'(bx0) * VW'(SCALE) + VW'(SUB_OFS));
    py0 = $signed(VW'(by0) * VW'(SCALE) + VW'(SUB_OFS));
    qx  = (sr == 2'd0) ? vx[2] : px0;
    qy  = (sr == 2'd0) ? vy[2] : py0;
    opa = step[0] ? dy[ej] : dx[ej];
    opb = step[0] ? (qx - vx[ej]) : (qy - vy[ej]);
    prod = opa * opb;
  end

  // bounding box
  logic [XW-1:0] mnx, mxx;
  logic [YW-1:0] mny, mxy;
  always_comb begin
    mnx = t[0]; mxx = t[0]; mny = t[1]; mxy = t[1];
    for (int i = 1; i < 3; i++) begin
      if (t[2*i] < mnx) mnx = t[2*i];
      if (t[2*i] > mxx) mxx = t[2*i];
      if (t[2*i+1] < mny) mny = t[2*i+1];
      if (t[2*i+1] > mxy) mxy = t[2*i+1];
    end
  end

  // subsample inside test, inclusive edges
  logic hit;
  logic last_sub;
  always_comb begin
    logic all_pos;
    logic all_neg;
    all_pos = 1'b1;
    all_neg = 1'b1;
    for (int j = 0; j < 3; j++) begin
      if (e_cur[j] < 0) all_pos = 1'b0;
      if (e_cur[j] > 0) all_neg = 1'b0;
    end
    hit      = area_pos ? all_pos : all_neg;
    last_sub = (sx == SUB_W'(SUBSAMPLES - 1)) && (sy == SUB_W'(SUBSAMPLES - 1));
  end

  // ring candidate
  logic signed [CW-1:0] cand_x, cand_y;
  logic                 out_x, out_y;
  logic [XW-1:0]        clamp_x;
  logic [YW-1:0]        clamp_y;
  logic [DIM_W-1:0]     wm1, hm1;
  always_comb begin
    wm1    = w_eff - DIM_W'(1);
    hm1    = h_eff - DIM_W'(1);
    cand_x = ring_step(cur_x, s, ring_dx(k));
    cand_y = ring_step(cur_y, s, ring_dy(k));
    out_x  = (cand_x < 0) || (cand_x >= $signed(CW'(w_eff)));
    out_y  = (cand_y < 0) || (cand_y >= $signed(CW'(h_eff)));
    if (cand_x < 0) clamp_x = '0;
    else if (cand_x >= $signed(CW'(w_eff))) clamp_x = wm1[XW-1:0];
    else clamp_x = cand_x[XW-1:0];
    if (cand_y < 0) clamp_y = '0;
    else if (cand_y >= $signed(CW'(h_eff))) clamp_y = hm1[YW-1:0];
    else clamp_y = cand_y[YW-1:0];
  end

  // memory port control
  always_comb begin
    cov_we    = 1'b0;
    cov_waddr = iy;
    cov_wdata = cov_rdata | hits;
    cov_raddr = iy;
    case (state)
      S_CLEAR: begin
        cov_we    = 1'b1;
        cov_waddr = row;
        cov_wdata = '0;
      end
      S_ROW_WR: cov_we = 1'b1;
      S_RD_COV: cov_raddr = cy;
      default: cov_raddr = iy;
    endcase
  end

  assign pop    = (state == S_IDLE) && head_valid;
  assign tex_we = pop && (head.func == FN_WRITE);

  assign back_status.init_clear = init_clear;
  assign done         = (state == S_RD_OUT);
  assign filled_value = tex_rdata;
  assign source_found = found;
  assign source_x     = src_x;
  assign source_y     = src_y;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      init_clear <= 1'b1;
      row        <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          row <= row + YW'(1);
          if (row == YW'(MAX_HEIGHT - 1)) begin
            state      <= S_IDLE;
            init_clear <= 1'b0;
          end
        end
        S_IDLE: begin
          if (head_valid) begin
            cur_x    <= head.x;
            cur_y    <= head.y;
            uv       <= head.uv;
            cidx     <= '0;
            row      <= '0;
            cx       <= head.x;
            cy       <= head.y;
            self_chk <= 1'b1;
            found    <= 1'b0;
            case (head.func)
              FN_CLEAR: state <= S_CLEAR;
              FN_TRI:   state <= S_CONV;
              FN_READ:  state <= S_RD_COV;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_CONV: begin
          t[cidx] <= conv_prod[16 +: XW];
          if (cidx == 3'd5) state <= S_BBOX;
          else cidx <= cidx + 3'd1;
        end
        S_BBOX: begin
          bx0   <= mnx;
          bx1   <= mxx;
          by0   <= mny;
          by1   <= mxy;
          step  <= '0;
          state <= S_SETUP;
        end
        S_SETUP: begin
          acc[sr] <= step[0] ? acc[sr] - EW'(prod) : EW'(prod);
          if (step == 3'd7) state <= S_START;
          else step <= step + 3'd1;
        end
        S_START: begin
          if (acc[0] == '0) begin
            state <= S_IDLE;
          end else begin
            area_pos <= !acc[0][EW-1];
            for (int j = 0; j < 3; j++) begin
              e_trow[j] <= acc[j+1];
              e_tex[j]  <= acc[j+1];
              e_srow[j] <= acc[j+1];
              e_cur[j]  <= acc[j+1];
            end
            ix    <= bx0;
            iy    <= by0;
            sx    <= '0;
            sy    <= '0;
            hits  <= '0;
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (hit || last_sub) begin
            if (hit) hits[ix] <= 1'b1;
            sx <= '0;
            sy <= '0;
            if (ix == bx1) begin
              state <= S_ROW_RD;
            end else begin
              ix <= ix + XW'(1);
              for (int j = 0; j < 3; j++) begin
                e_tex[j]  <= e_tex[j] + tex_x[j];
                e_srow[j] <= e_tex[j] + tex_x[j];
                e_cur[j]  <= e_tex[j] + tex_x[j];
              end
            end
          end else if (sx == SUB_W'(SUBSAMPLES - 1)) begin
            sx <= '0;
            sy <= sy + SUB_W'(1);
            for (int j = 0; j < 3; j++) begin
              e_srow[j] <= e_srow[j] + sub_y[j];
              e_cur[j]  <= e_srow[j] + sub_y[j];
            end
          end else begin
            sx <= sx + SUB_W'(1);
            for (int j = 0; j < 3; j++) begin
              e_cur[j] <= e_cur[j] + sub_x[j];
            end
          end
        end
        S_ROW_RD: state <= S_ROW_WR;
        S_ROW_WR: begin
          hits <= '0;
          if (iy == by1) begin
            state <= S_IDLE;
          end else begin
            iy <= iy + YW'(1);
            ix <= bx0;
            for (int j = 0; j < 3; j++) begin
              e_trow[j] <= e_trow[j] + tex_y[j];
              e_tex[j]  <= e_trow[j] + tex_y[j];
              e_srow[j] <= e_trow[j] + tex_y[j];
              e_cur[j]  <= e_trow[j] + tex_y[j];
            end
            state <= S_TEST;
          end
        end
        S_RD_COV: state <= S_RD_CHK;
        S_RD_CHK: begin
          if (cov_rdata[cx]) begin
            found <= 1'b1;
            src_x <= cx;
            src_y <= cy;
            state <= S_RD_VAL;
          end else begin
            if (self_chk) begin
              self_chk <= 1'b0;
              s        <= RING_W'(1);
              k        <= '0;
            end else if (k == 3'd7) begin
              s <= s + RING_W'(1);
              k <= '0;
            end else begin
              k <= k + 3'd1;
            end
            state <= S_RD_NEXT;
          end
        end
        S_RD_NEXT: begin
          if (out_x && out_y) begin
            if (k == 3'd7) begin
              found <= 1'b0;
              src_x <= cur_x;
              src_y <= cur_y;
              state <= S_RD_VAL;
            end else begin
              k <= k + 3'd1;
            end
          end else begin
            cx    <= clamp_x;
            cy    <= clamp_y;
            state <= S_RD_COV;
          end
        end
        S_RD_VAL: state <= S_RD_OUT;
        S_RD_OUT: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/lightmap_coverage_gutter_fill_unit.sv
// Lightmap coverage and gutter fill. Requests enter through start/busy into a
// two-deep queue; the back end runs one request at a time. A write stores its
// value as it leaves the queue; a clear dispatches, then clears one coverage
// row a cycle. A triangle first sets up (dispatch, six uv conversions,
// bounding box, edge setup multiplies, area check), then runs one
// subsample test per cycle, up to 64 per texel of its bounding box and
// stopping at the first inside subsample, plus a coverage row read and write
// per bounding box row. A read checks the texel itself, then probes neighbors
// ring by ring through the one coverage memory read port, skipping ring
// offsets that fall outside the area on both axes, and then reads the value.
// After reset the coverage memory is cleared with busy high. A read gives one
// result, shown for exactly one cycle with done high; the receiver cannot stall
// it. Configuration writes take effect at once and belong in idle periods.
module lightmap_coverage_gutter_fill_unit import lgf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic [XW-1:0]         texel_x,
  input  logic [YW-1:0]         texel_y,
  input  logic [VALUE_BITS-1:0] texel_value,
  input  logic [UV_W-1:0]       u_first,
  input  logic [UV_W-1:0]       v_first,
  input  logic [UV_W-1:0]       u_second,
  input  logic [UV_W-1:0]       v_second,
  input  logic [UV_W-1:0]       u_third,
  input  logic [UV_W-1:0]       v_third,
  output logic                  done,
  output logic [VALUE_BITS-1:0] filled_value,
  output logic                  source_found,
  output logic [XW-1:0]         source_x,
  output logic [YW-1:0]         source_y
);

  logic [DIM_W-1:0] active_width;
  logic [DIM_W-1:0] active_height;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  entry_t           head;
  logic             head_valid;
  logic             pop;
  back_status_t     back_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= DIM_W'(MAX_WIDTH);
      active_height <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) active_width <= cfg_data;
      if (cfg_index == REG_HEIGHT) active_height <= cfg_data;
    end
  end

  // active size saturated to the supported range
  always_comb begin
    if (active_width == '0) w_eff = DIM_W'(1);
    else if (active_width > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = active_width;
    if (active_height == '0) h_eff = DIM_W'(1);
    else if (active_height > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = active_height;
  end

  lgf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .texel_x     (texel_x),
    .texel_y     (texel_y),
    .texel_value (texel_value),
    .u_first     (u_first),
    .v_first     (v_first),
    .u_second    (u_second),
    .v_second    (v_second),
    .u_third     (u_third),
    .v_third     (v_third),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .back_status (back_status),
    .pop         (pop),
    .head        (head),
    .head_valid  (head_valid)
  );

  lgf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .back_status  (back_status),
    .done         (done),
    .filled_value (filled_value),
    .source_found (source_found),
    .source_x     (source_x),
    .source_y     (source_y)
  );

endmodule

### sv/lgf_checker.sv
module lgf_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done
);

  // coverage clear pass holds off requests after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // no result right after reset
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

  // a read passes through its lookup states before each result, so results never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results in consecutive cycles");

  // a result never follows directly on reset
  a_done_needs_request: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result without request");

endmodule

bind lightmap_coverage_gutter_fill_unit lgf_checker u_lgf_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .done  (done)
);
